// ----- src/bounding_box_overlap_merge_macros.svh -----
// bounding_box_overlap_merge_macros.svh: assertion macros for the checker
// no dependencies
`ifndef BOUNDING_BOX_OVERLAP_MERGE_MACROS_SVH
`define BOUNDING_BOX_OVERLAP_MERGE_MACROS_SVH

// same-cycle implication, disabled in reset
`define BBOM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbom assertion failed");

// next-cycle implication, disabled in reset
`define BBOM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbom assertion failed");

`endif

// ----- src/bbom_pkg.sv -----
// bbom_pkg: shared types and constants of the bounding box merge block
// no dependencies
package bbom_pkg;

  // fixed widths of the configuration port
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 1;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // reset values of the image size
  localparam logic [CfgDataW-1:0] ImageWidthRst  = 13'd640;
  localparam logic [CfgDataW-1:0] ImageHeightRst = 13'd480;

  // largest rejected area: this value and below are rejected
  localparam int unsigned MinArea = 10;

  // sequencer states
  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_RDI   = 8'b0000_0010,
    ST_LDI   = 8'b0000_0100,
    ST_CMP   = 8'b0000_1000,
    ST_CPY   = 8'b0001_0000,
    ST_OUT   = 8'b0010_0000,
    ST_OLD   = 8'b0100_0000,
    ST_OHOLD = 8'b1000_0000
  } state_e;

endpackage

// ----- src/bounding_box_overlap_merge.sv -----
// bounding_box_overlap_merge: loads one rectangle per cycle while in load state.
// after the last item, the pair scan reads each outer box and checks it against each
// later box; each merge copies the survivors into the other bank, then rescans.
// each result is read, loaded and transferred before the next one is read.
// reset: async active low; store empty, image size 640x480, no result pending.
module bounding_box_overlap_merge #(
  parameter int unsigned MAX_BOXES  = 64,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbom_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bbom_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          has_rect_i,
  input  logic [COORD_BITS-1:0]         left_x_i,
  input  logic [COORD_BITS-1:0]         top_y_i,
  input  logic [COORD_BITS:0]           box_width_i,
  input  logic [COORD_BITS:0]           box_height_i,
  input  logic                          frame_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [COORD_BITS-1:0]         out_x_o,
  output logic [COORD_BITS-1:0]         out_y_o,
  output logic [COORD_BITS:0]           out_width_o,
  output logic [COORD_BITS:0]           out_height_o,
  output logic                          none_found_o,
  output logic                          out_last_o
);
  import bbom_pkg::*;

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned SW    = COORD_BITS + 1;
  localparam int unsigned RW    = COORD_BITS + 2;
  localparam int unsigned EW    = 2 * CW + 2 * SW;
  localparam int unsigned IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);

  // configuration registers
  logic [CfgDataW-1:0] img_w_q, img_h_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= ImageWidthRst;
      img_h_q <= ImageHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  img_w_q <= cfg_data_i;
        CFG_IMAGE_HEIGHT: img_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // area filter
  logic keep;
  bbom_area #(.SW(SW)) u_area (
    .img_w_i (img_w_q),
    .img_h_i (img_h_q),
    .box_w_i (box_width_i),
    .box_h_i (box_height_i),
    .keep_o  (keep)
  );

  // control state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IDX_W-1:0]   pidx_q, pidx_d, wp_q, wp_d;
  logic [CNT_W-1:0]   rd_q, rd_d;
  logic               pend_q, pend_d, bank_q, bank_d;
  logic               ovalid_q, ovalid_d;
  logic [EW-1:0]      boxi_q, boxi_d;
  logic [CW-1:0]      ox_q, ox_d, oy_q, oy_d;
  logic [SW-1:0]      ow_q, ow_d, oh_q, oh_d;
  logic               onone_q, onone_d, olast_q, olast_d;

  // memory port
  logic             mwe, mwother;
  logic [IDX_W-1:0] mwaddr, mraddr;
  logic [EW-1:0]    mwdata, mrdata;

  bbom_mem #(.DEPTH(MAX_BOXES), .WIDTH(EW), .AW(IDX_W)) u_mem (
    .clk_i    (clk_i),
    .bank_i   (bank_q),
    .we_i     (mwe),
    .wother_i (mwother),
    .waddr_i  (mwaddr),
    .wdata_i  (mwdata),
    .raddr_i  (mraddr),
    .rdata_o  (mrdata)
  );

  // geometry of the held box and the box just read
  logic [CW-1:0] ax, ay, bx, by, ux, uy;
  logic [SW-1:0] aw, ah, bw, bh;
  logic [RW-1:0] ar, ad, br, bd, lx, ty, rmin, dmin, rmax, dmax;
  logic          ovl;
  logic [EW-1:0] uni;
  always_comb begin
    ax = boxi_q[EW-1 -: CW];
    ay = boxi_q[2*SW+CW-1 -: CW];
    aw = boxi_q[2*SW-1 -: SW];
    ah = boxi_q[SW-1:0];
    bx = mrdata[EW-1 -: CW];
    by = mrdata[2*SW+CW-1 -: CW];
    bw = mrdata[2*SW-1 -: SW];
    bh = mrdata[SW-1:0];
    ar = RW'(ax) + RW'(aw);
    ad = RW'(ay) + RW'(ah);
    br = RW'(bx) + RW'(bw);
    bd = RW'(by) + RW'(bh);
    lx = (ax > bx) ? RW'(ax) : RW'(bx);
    ty = (ay > by) ? RW'(ay) : RW'(by);
    ux = (ax < bx) ? ax : bx;
    uy = (ay < by) ? ay : by;
    rmin = (ar < br) ? ar : br;
    dmin = (ad < bd) ? ad : bd;
    rmax = (ar > br) ? ar : br;
    dmax = (ad > bd) ? ad : bd;
    ovl = (rmin > lx) && (dmin > ty);
    uni = {ux, uy, SW'(rmax - RW'(ux)), SW'(dmax - RW'(uy))};
  end

  logic in_acc, out_acc, store_it;
  assign in_acc   = in_valid_i && (state_q == ST_LOAD);
  assign out_acc  = ovalid_q && !out_stall_i;
  assign store_it = in_acc && has_rect_i && keep && (count_q < CNT_W'(MAX_BOXES));

  // sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    pidx_d   = pidx_q;
    wp_d     = wp_q;
    rd_d     = rd_q;
    pend_d   = pend_q;
    bank_d   = bank_q;
    ovalid_d = ovalid_q;
    boxi_d   = boxi_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    ow_d     = ow_q;
    oh_d     = oh_q;
    onone_d  = onone_q;
    olast_d  = olast_q;
    mwe      = 1'b0;
    mwother  = 1'b0;
    mwaddr   = '0;
    mwdata   = mrdata;
    mraddr   = '0;
    case (state_q)
      // collect rectangles
      ST_LOAD: begin
        if (store_it) begin
          mwe     = 1'b1;
          mwaddr  = count_q[IDX_W-1:0];
          mwdata  = {left_x_i, top_y_i, box_width_i, box_height_i};
          count_d = count_q + 1'b1;
        end
        if (in_acc && frame_last_i) begin
          i_d = '0;
          k_d = '0;
          state_d = (count_d >= CNT_W'(2)) ? ST_RDI : ST_OUT;
        end
      end
      // fetch outer box
      ST_RDI: begin
        mraddr  = i_q;
        state_d = ST_LDI;
      end
      ST_LDI: begin
        boxi_d  = mrdata;
        j_d     = IDX_W'(CNT_W'(i_q) + 1'b1);
        mraddr  = IDX_W'(CNT_W'(i_q) + 1'b1);
        state_d = ST_CMP;
      end
      // compare against inner box
      ST_CMP: begin
        if (ovl) begin
          mwe     = 1'b1;
          mwother = 1'b1;
          mwaddr  = '0;
          mwdata  = uni;
          rd_d    = '0;
          pend_d  = 1'b0;
          wp_d    = IDX_W'(1);
          state_d = ST_CPY;
        end else if (CNT_W'(j_q) + 1'b1 < count_q) begin
          j_d    = IDX_W'(CNT_W'(j_q) + 1'b1);
          mraddr = IDX_W'(CNT_W'(j_q) + 1'b1);
        end else if (CNT_W'(i_q) + CNT_W'(2) < count_q) begin
          i_d     = IDX_W'(CNT_W'(i_q) + 1'b1);
          state_d = ST_RDI;
        end else begin
          k_d     = '0;
          state_d = ST_OUT;
        end
      end
      // copy survivors behind the union into the other bank
      ST_CPY: begin
        if (rd_q < count_q) begin
          mraddr = rd_q[IDX_W-1:0];
          rd_d   = rd_q + 1'b1;
          pend_d = 1'b1;
          pidx_d = rd_q[IDX_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && (pidx_q != i_q) && (pidx_q != j_q)) begin
          mwe     = 1'b1;
          mwother = 1'b1;
          mwaddr  = wp_q;
          mwdata  = mrdata;
          wp_d    = wp_q + 1'b1;
        end
        if ((rd_q == count_q) && !pend_q) begin
          count_d = count_q - 1'b1;
          bank_d  = !bank_q;
          i_d     = '0;
          k_d     = '0;
          state_d = (count_q - 1'b1 >= CNT_W'(2)) ? ST_RDI : ST_OUT;
        end
      end
      // emit results
      ST_OUT: begin
        if (count_q == '0) begin
          ox_d     = '0;
          oy_d     = '0;
          ow_d     = '0;
          oh_d     = '0;
          onone_d  = 1'b1;
          olast_d  = 1'b1;
          ovalid_d = 1'b1;
          state_d  = ST_OHOLD;
        end else begin
          mraddr  = k_q;
          state_d = ST_OLD;
        end
      end
      ST_OLD: begin
        ox_d     = bx;
        oy_d     = by;
        ow_d     = bw;
        oh_d     = bh;
        onone_d  = 1'b0;
        olast_d  = (CNT_W'(k_q) + 1'b1 == count_q);
        ovalid_d = 1'b1;
        state_d  = ST_OHOLD;
      end
      ST_OHOLD: begin
        if (out_acc) begin
          ovalid_d = 1'b0;
          if (olast_q) begin
            count_d = '0;
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_OUT;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      count_q  <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      pidx_q   <= '0;
      wp_q     <= '0;
      rd_q     <= '0;
      pend_q   <= 1'b0;
      bank_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      pidx_q   <= pidx_d;
      wp_q     <= wp_d;
      rd_q     <= rd_d;
      pend_q   <= pend_d;
      bank_q   <= bank_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    boxi_q  <= boxi_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    ow_q    <= ow_d;
    oh_q    <= oh_d;
    onone_q <= onone_d;
    olast_q <= olast_d;
  end

  assign in_stall_o   = (state_q != ST_LOAD);
  assign out_valid_o  = ovalid_q;
  assign out_x_o      = ox_q;
  assign out_y_o      = oy_q;
  assign out_width_o  = ow_q;
  assign out_height_o = oh_q;
  assign none_found_o = onone_q;
  assign out_last_o   = olast_q;

endmodule

// ----- src/bbom_mem.sv -----
// bbom_mem: two banks of rectangle storage, one active and one copy target
// depends on nothing; one write and one registered read per cycle
module bbom_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 50,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             bank_i,
  input  logic             we_i,
  input  logic             wother_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem0 [DEPTH];
  logic [WIDTH-1:0] mem1 [DEPTH];
  logic [WIDTH-1:0] rd0_q, rd1_q;
  logic             sel_q;
  logic             wbank;

  assign wbank = bank_i ^ wother_i;

  // write port, steered to the active bank or the other one
  always_ff @(posedge clk_i) begin
    if (we_i && !wbank) begin
      mem0[waddr_i] <= wdata_i;
    end
    if (we_i && wbank) begin
      mem1[waddr_i] <= wdata_i;
    end
  end

  // registered read of the active bank
  always_ff @(posedge clk_i) begin
    rd0_q <= mem0[raddr_i];
    rd1_q <= mem1[raddr_i];
    sel_q <= bank_i;
  end

  assign rdata_o = sel_q ? rd1_q : rd0_q;

endmodule

// ----- src/bbom_area.sv -----
// bbom_area: area filter for incoming rectangles
// depends on bbom_pkg; image area product is formed from the current config values
module bbom_area #(
  parameter int unsigned SW = 13
) (
  input  logic [bbom_pkg::CfgDataW-1:0] img_w_i,
  input  logic [bbom_pkg::CfgDataW-1:0] img_h_i,
  input  logic [SW-1:0]                 box_w_i,
  input  logic [SW-1:0]                 box_h_i,
  output logic                          keep_o
);
  import bbom_pkg::*;

  localparam int unsigned LimW = 2 * CfgDataW;
  localparam int unsigned AreaW = 2 * SW;
  localparam int unsigned CmpW = (AreaW + 3 > LimW + 2) ? AreaW + 3 : LimW + 2;

  logic [LimW-1:0]  lim;
  logic [AreaW-1:0] area;
  logic [CmpW-1:0]  area5, lim4;

  // keep when area > 10 and 5*area < 4*W*H
  always_comb begin
    lim    = img_w_i * img_h_i;
    area   = box_w_i * box_h_i;
    area5  = (CmpW'(area) << 2) + CmpW'(area);
    lim4   = CmpW'(lim) << 2;
    keep_o = (area > AreaW'(MinArea)) && (area5 < lim4);
  end

endmodule

// ----- src/bbom_checker.sv -----
// bbom_checker: port-level assertions for bounding_box_overlap_merge, with bind
// depends on bounding_box_overlap_merge_macros.svh
`include "bounding_box_overlap_merge_macros.svh"

module bbom_checker #(
  parameter int unsigned COORD_BITS = 12
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  frame_last_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [COORD_BITS-1:0] out_x_o,
  input logic [COORD_BITS-1:0] out_y_o,
  input logic [COORD_BITS:0]   out_width_o,
  input logic [COORD_BITS:0]   out_height_o,
  input logic                  none_found_o,
  input logic                  out_last_o
);

  // a stalled result holds
  `BBOM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_x_o) && $stable(out_width_o) && $stable(out_last_o))

  // empty frame result is a single zero last transfer
  `BBOM_ASSERT_IMPL(a_none_last, clk_i, rst_ni, out_valid_o && none_found_o, out_last_o && out_x_o == '0 && out_y_o == '0 && out_width_o == '0 && out_height_o == '0)

  // no input transfer while results are pending
  `BBOM_ASSERT_IMPL(a_out_blocks_in, clk_i, rst_ni, out_valid_o, in_stall_o)

  // a non-final input transfer produces no result
  `BBOM_ASSERT_NEXT(a_no_early_out, clk_i, rst_ni, in_valid_i && !in_stall_o && !frame_last_i, !out_valid_o && !in_stall_o)

endmodule

bind bounding_box_overlap_merge bbom_checker #(.COORD_BITS(COORD_BITS)) u_bbom_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .frame_last_i (frame_last_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_x_o      (out_x_o),
  .out_y_o      (out_y_o),
  .out_width_o  (out_width_o),
  .out_height_o (out_height_o),
  .none_found_o (none_found_o),
  .out_last_o   (out_last_o)
);

// ----- tb/testbench.sv -----
// testbench: self-checking bench for bounding_box_overlap_merge
// depends on bbom_pkg and the bounding_box_overlap_merge rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bbom_pkg::*;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
  } rect_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
    logic        none;
    logic        last;
  } merged_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_IMAGE_WIDTH;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic has_rect_i = 1'b0;
  logic [11:0] left_x_i = '0;
  logic [11:0] top_y_i = '0;
  logic [12:0] box_width_i = '0;
  logic [12:0] box_height_i = '0;
  logic frame_last_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [11:0] out_x_o;
  logic [11:0] out_y_o;
  logic [12:0] out_width_o;
  logic [12:0] out_height_o;
  logic none_found_o;
  logic out_last_o;

  bounding_box_overlap_merge dut (.*);

  // predictor state
  rect_t   kept_boxes[$];
  merged_t merged_queue[$];
  int unsigned img_w = 640;
  int unsigned img_h = 480;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int frames_sent = 0;
  longint cycle_count = 0;
  int stall_mode = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("bounding_box_overlap_merge: mismatch");
      $finish;
    end
  end

  function automatic logic rects_overlap(rect_t a, rect_t b);
    int unsigned l, t, r, d, ar, ad, br, bd;
    ar = a.x + a.w;
    ad = a.y + a.h;
    br = b.x + b.w;
    bd = b.y + b.h;
    l = (a.x > b.x) ? a.x : b.x;
    t = (a.y > b.y) ? a.y : b.y;
    r = (ar < br) ? ar : br;
    d = (ad < bd) ? ad : bd;
    return (r > l) && (d > t);
  endfunction

  function automatic rect_t rects_union(rect_t a, rect_t b);
    rect_t u;
    int unsigned r, d, ux, uy, ar, ad, br, bd;
    ar = a.x + a.w;
    ad = a.y + a.h;
    br = b.x + b.w;
    bd = b.y + b.h;
    r = (ar > br) ? ar : br;
    d = (ad > bd) ? ad : bd;
    ux = (a.x < b.x) ? a.x : b.x;
    uy = (a.y < b.y) ? a.y : b.y;
    u.x = ux[11:0];
    u.y = uy[11:0];
    u.w = 13'(r - ux);
    u.h = 13'(d - uy);
    return u;
  endfunction

  // frame predictor: filter, merge on last, queue results
  task automatic predict_frame_item(logic has, rect_t b, logic last);
    longint unsigned area;
    int i, j;
    logic merged;
    rect_t u;
    merged_t m;
    area = longint'(b.w) * longint'(b.h);
    if (has && area > 10 && 5 * area < 4 * longint'(img_w) * longint'(img_h)
        && kept_boxes.size() < 64)
      kept_boxes = {kept_boxes, b};
    if (!last) return;
    i = 0;
    while (i + 1 < kept_boxes.size()) begin
      merged = 1'b0;
      for (j = i + 1; j < kept_boxes.size(); j++) begin
        if (rects_overlap(kept_boxes[i], kept_boxes[j])) begin
          u = rects_union(kept_boxes[i], kept_boxes[j]);
          kept_boxes.delete(j);
          kept_boxes.delete(i);
          kept_boxes = {u, kept_boxes};
          merged = 1'b1;
          break;
        end
      end
      i = merged ? 0 : i + 1;
    end
    if (kept_boxes.size() == 0) begin
      m = '0;
      m.none = 1'b1;
      m.last = 1'b1;
      merged_queue = {merged_queue, m};
    end else begin
      foreach (kept_boxes[k]) begin
        m.x = kept_boxes[k].x;
        m.y = kept_boxes[k].y;
        m.w = kept_boxes[k].w;
        m.h = kept_boxes[k].h;
        m.none = 1'b0;
        m.last = (k == kept_boxes.size() - 1);
        merged_queue = {merged_queue, m};
      end
    end
    kept_boxes.delete();
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 1) == 0);
    endcase
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  // result checker
  always @(posedge clk_i) begin
    merged_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (merged_queue.size() == 0) begin
        $display("%0t unexpected result x=%0d y=%0d w=%0d h=%0d", $realtime,
                 out_x_o, out_y_o, out_width_o, out_height_o);
        errors++;
      end else begin
        want = merged_queue.pop_front();
        if (out_x_o !== want.x || out_y_o !== want.y || out_width_o !== want.w ||
            out_height_o !== want.h || none_found_o !== want.none ||
            out_last_o !== want.last) begin
          $display("%0t expected x=%0d y=%0d w=%0d h=%0d none=%0b last=%0b",
                   $realtime, want.x, want.y, want.w, want.h, want.none, want.last);
          $display("%0t actual   x=%0d y=%0d w=%0d h=%0d none=%0b last=%0b",
                   $realtime, out_x_o, out_y_o, out_width_o, out_height_o,
                   none_found_o, out_last_o);
          errors++;
        end
      end
    end
  end

  // one input transfer, with an occasional random gap first
  task automatic send_rect(logic has, int x, int y, int w, int h, logic last);
    rect_t b;
    if ($urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    b.x = x[11:0];
    b.y = y[11:0];
    b.w = w[12:0];
    b.h = h[12:0];
    in_valid_i <= 1'b1;
    has_rect_i <= has;
    left_x_i <= b.x;
    top_y_i <= b.y;
    box_width_i <= b.w;
    box_height_i <= b.h;
    frame_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_frame_item(has, b, last);
    items_sent++;
    if (last) frames_sent++;
  endtask

  task automatic end_transfers();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // write a register only with the block drained and settled
  task automatic write_image_size(int unsigned w, int unsigned h);
    int guard;
    end_transfers();
    guard = 0;
    while (merged_queue.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_IMAGE_WIDTH;
    cfg_data_i <= w[12:0];
    @(posedge clk_i);
    cfg_index_i <= CFG_IMAGE_HEIGHT;
    cfg_data_i <= h[12:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    img_w = w;
    img_h = h;
  endtask

  // directed: area limits, end markers, identical and chained overlaps
  task automatic test_directed();
    send_rect(1, 0, 0, 0, 0, 0);
    send_rect(1, 10, 10, 11, 1, 0);
    send_rect(1, 100, 100, 10, 1, 0);
    send_rect(1, 4095, 4095, 4096, 4096, 1);
    send_rect(0, 0, 0, 5, 5, 1);
    send_rect(1, 5, 5, 20, 20, 0);
    send_rect(1, 5, 5, 20, 20, 0);
    send_rect(0, 4095, 4095, 8191, 8191, 0);
    send_rect(1, 24, 24, 10, 10, 0);
    send_rect(1, 300, 300, 10, 10, 0);
    send_rect(1, 310, 300, 10, 10, 1);
    send_rect(1, 0, 0, 511, 480, 1);
    send_rect(1, 0, 0, 512, 480, 1);
    send_rect(1, 4095, 0, 4096, 12, 0);
    send_rect(1, 0, 4095, 12, 4096, 1);
  endtask

  // store capacity: 70 disjoint boxes in one frame
  task automatic test_store_full();
    for (int k = 0; k < 70; k++)
      send_rect(1, (k % 10) * 50, (k / 10) * 50, 20, 20, k == 69);
  endtask

  // random frames, mostly small clustered boxes
  task automatic test_random(int count);
    int n, span;
    logic last;
    n = 0;
    while (n < count) begin
      span = ($urandom_range(0, 3) == 0) ? 4095 : 300;
      for (int k = $urandom_range(1, 12); k > 0; k--) begin
        last = (k == 1);
        if ($urandom_range(0, 9) == 0)
          send_rect($urandom_range(0, 1), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 8191),
                    $urandom_range(0, 8191), last);
        else
          send_rect(($urandom_range(0, 15) != 0), $urandom_range(0, span),
                    $urandom_range(0, span), $urandom_range(0, 60),
                    $urandom_range(0, 60), last);
        n++;
      end
    end
  endtask

  initial begin
    int guard;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_store_full();
    test_random(60);
    write_image_size(1, 1);
    send_rect(1, 0, 0, 4, 4, 1);
    write_image_size(4096, 4096);
    send_rect(1, 0, 0, 4096, 3276, 0);
    send_rect(1, 0, 0, 4096, 3277, 1);
    test_random(60);
    write_image_size(8191, 0);
    send_rect(1, 1, 1, 5, 5, 1);
    write_image_size(37, 23);
    test_random(45);
    write_image_size(640, 480);
    send_rect(1, 0, 0, 40, 40, 1);
    end_transfers();
    guard = 0;
    while (merged_queue.size() != 0 && guard < 500000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (50) @(posedge clk_i);
    $display("sent %0d items in %0d frames, checked %0d results", items_sent,
             frames_sent, results_seen);
    $display("image sizes covered extremes, zero height and small frames");
    if (errors == 0 && merged_queue.size() == 0) begin
      $display("bounding_box_overlap_merge: match");
    end else begin
      $display("bounding_box_overlap_merge: mismatch");
    end
    $finish;
  end
endmodule

// ----- bounding_box_overlap_merge.f -----
+incdir+src
src/bbom_pkg.sv
src/bbom_mem.sv
src/bbom_area.sv
src/bounding_box_overlap_merge.sv
src/bbom_checker.sv
tb/testbench.sv
